@@ src/lkv_pkg.sv @@
// lkv_pkg: shared types and constants for the LRU key-value cache.
// Used by lkv_store, lru_key_value_cache, lkv_checker and the testbench; no dependencies.
`default_nettype none

package lkv_pkg;

    // Default table depth and capacity register reset value
    localparam int LKV_ENTRIES = 16;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Value returned by a get that misses
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    // Operation codes
    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // Registered request handed to the table
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } lkv_req_t;

    // Lookup answer from the table
    typedef struct packed {
        logic               hit;
        logic signed [31:0] value;
    } lkv_look_t;

endpackage

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// lru_key_value_cache: top level with request register, lkv_store table and
// result register. Uses lkv_pkg and lkv_store.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------
//   request | in        | start, busy        | op, key, value
//   result  | out       | done (strobe)      | hit, read_value
//   config  | in        | cfg_we             | cfg_wdata (capacity)
//
// One item is taken every cycle; busy stays low. A get's result strobes on
// done after the request register, the combinational tag match and rank
// update over the register table, and the result register. A put gives
// no result. Reset clears valid bits, ranks, the entry count and sets
// capacity to 16; there is no clearing pass. The receiver cannot stall, so
// nothing is held back.
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       op,
    input  wire logic signed [31:0]         key,
    input  wire logic signed [31:0]         value,
    output logic                            done,
    output logic                            hit,
    output logic signed [31:0]              read_value,
    input  wire logic                       cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]  cfg_wdata
);
    import lkv_pkg::*;

    logic               req_valid_reg;
    op_t                req_op_reg;
    logic signed [31:0] req_key_reg;
    logic signed [31:0] req_value_reg;
    lkv_req_t           req;
    lkv_look_t          look;

    logic               done_reg;
    logic               hit_reg;
    logic signed [31:0] read_value_reg;

    // Table pipeline never backs up
    assign busy = 1'b0;

    // Capture the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_op_reg    <= op_t'(op);
            req_key_reg   <= key;
            req_value_reg <= value;
        end
    end

    assign req.valid = req_valid_reg;
    assign req.op    = req_op_reg;
    assign req.key   = req_key_reg;
    assign req.value = req_value_reg;

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .look      (look)
    );

    // Register the get result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= req_valid_reg && (req_op_reg == OP_GET);
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= look.hit;
        read_value_reg <= look.hit ? look.value : MISS_VALUE;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

@@ src/lkv_store.sv @@
// lkv_store: register table of keys, values, valid bits and recency ranks,
// with the parallel key match, LRU victim pick and rank update. Uses lkv_pkg.
`default_nettype none

module lkv_store #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
    input  wire lkv_pkg::lkv_req_t           req,
    output lkv_pkg::lkv_look_t               look
);
    import lkv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Control state
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [IW-1:0]       rank_reg  [ENTRIES];
    logic [IW-1:0]       rank_next [ENTRIES];
    logic [CW-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]    capacity_reg;

    // Payload storage
    logic signed [31:0]  key_reg [ENTRIES];
    logic signed [31:0]  val_reg [ENTRIES];

    // Lookup and victim selection
    logic [ENTRIES-1:0]  match_vec;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       hit_rank;
    logic signed [31:0]  hit_value;
    logic [IW-1:0]       free_idx;
    logic [IW-1:0]       lru_idx;
    logic [CW-1:0]       lru_rank;
    logic [CW-1:0]       eff_cap;
    logic                full;
    logic [IW-1:0]       slot;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;

    // Match every entry at once and gather the matching entry's fields
    always_comb
    begin
        hit_idx   = '0;
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match_vec[i])
            begin
                hit_idx   = hit_idx | IW'(i);
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | val_reg[i];
            end
        end
        hit = |match_vec;
    end

    // Clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (32'(capacity_reg) > 32'(ENTRIES))
            eff_cap = CW'(ENTRIES);
        else if (capacity_reg == '0)
            eff_cap = CW'(1);
        else
            eff_cap = CW'(capacity_reg);
        full = (count_reg >= eff_cap);
    end

    // Pick first free slot and the least recent entry
    always_comb
    begin
        free_idx = '0;
        lru_idx  = '0;
        lru_rank = count_reg - CW'(1);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IW'(i);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && (CW'(rank_reg[i]) == lru_rank))
                lru_idx = IW'(i);
        end
        slot = full ? lru_idx : free_idx;
    end

    // Next valid bits, ranks and count
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = slot;
        for (int i = 0; i < ENTRIES; i++)
            rank_next[i] = rank_reg[i];

        if (req.valid && hit)
        begin
            // Promote the hit entry: newer entries age by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
            rank_next[hit_idx] = '0;
            wr_en  = (req.op == OP_PUT);
            wr_idx = hit_idx;
        end
        else if (req.valid && (req.op == OP_PUT))
        begin
            // Insert as most recent, reusing the LRU slot when full
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i])
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
            rank_next[slot]  = '0;
            valid_next[slot] = 1'b1;
            wr_en            = 1'b1;
            if (!full)
                count_next = count_reg + CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= CAPACITY_RESET;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
            // Capacity only changes while the table is empty
            if (cfg_we && (count_reg == '0))
                capacity_reg <= cfg_wdata;
        end
    end

    // Key and value storage, written at one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg[wr_idx] <= req.key;
            val_reg[wr_idx] <= req.value;
        end
    end

    assign look.hit   = hit;
    assign look.value = hit_value;

endmodule

`default_nettype wire

@@ src/lkv_checker.sv @@
// lkv_checker: port-level assertions for lru_key_value_cache, bound to it.
// Uses lkv_pkg for the op codes and miss value.
`default_nettype none

module lkv_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               op,
    input wire logic               done,
    input wire logic               hit,
    input wire logic signed [31:0] read_value
);
    import lkv_pkg::*;

    // Every accepted get yields a result once it has passed the request and result registers
    a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_GET)) |=> ##1 done)
        else $error("accepted get produced no result");

    // Every accepted put yields no result
    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_PUT)) |=> ##1 !done)
        else $error("put produced a result");

    // No result without an accepted get that has passed the request and result registers
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (op == OP_GET) && rst_n, 2))
        else $error("result without an accepted get");

    // A miss always reports the miss value
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == MISS_VALUE))
        else $error("miss did not return the miss value");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .done       (done),
    .hit        (hit),
    .read_value (read_value)
);

`default_nettype wire

@@ sim/tb_lru_key_value_cache.sv @@
// tb_lru_key_value_cache: self-checking testbench for the LRU key-value cache.
// Directed table then random get/put traffic, checked against a behavioral
// shadow of the table. Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    import lkv_pkg::*;

    localparam int          N_SLOTS     = LKV_ENTRIES;
    localparam int          DIR_N       = 25;
    localparam int          RAND_PHASES = 5;
    localparam int          PHASE_ITEMS = 306;
    localparam int          POOL_MAX    = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [31:0] NO_HIT      = MISS_VALUE;

    typedef struct {
        logic        hit;
        logic [31:0] value;
    } lookup_t;

    typedef struct {
        op_t         op;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        logic        exp_hit;
        logic [31:0] exp_value;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic signed [31:0]  key;
    logic signed [31:0]  value;
    logic                done;
    logic                hit;
    logic signed [31:0]  read_value;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_wdata;

    // Shadow copy of the cache table
    bit                  shadow_valid [N_SLOTS];
    logic [31:0]         shadow_key   [N_SLOTS];
    logic [31:0]         shadow_value [N_SLOTS];
    int unsigned         shadow_rank  [N_SLOTS];
    int unsigned         shadow_count;
    logic [CAP_W-1:0]    shadow_capacity;

    lookup_t             lookups_due [$];
    int unsigned         lookup_errors;
    int unsigned         cycle_count;

    logic [31:0]         key_pool [POOL_MAX];
    int                  pool_n;

    // Directed items: typed expectations only where they are obvious
    dir_row_t dir_rows [DIR_N] = '{
        '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_HIT},
        '{OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_HIT},
        '{OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_HIT},
        '{OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
        '{OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
        '{OP_PUT, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0001_2345, 32'h0000_0000, 1'b1, 1'b0, NO_HIT},
        '{OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_PUT, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{OP_PUT, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{OP_PUT, 32'h0000_0003, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{OP_GET, 32'h0000_0003, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000}
    };

    lru_key_value_cache uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .key        (key),
        .value      (value),
        .done       (done),
        .hit        (hit),
        .read_value (read_value),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp the capacity register to the usable range
    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = shadow_capacity;
        if (c == 0)
            c = 1;
        if (c > N_SLOTS)
            c = N_SLOTS;
        return c;
    endfunction

    // Advance the shadow table by one item and return what a get reports
    task automatic predict_lookup(input op_t o, input logic [31:0] k, input logic [31:0] v,
                                  output bit gives, output lookup_t res);
        int          found;
        int          slot;
        int unsigned r;
        found = -1;
        for (int i = 0; i < N_SLOTS; i++)
            if (found < 0 && shadow_valid[i] && shadow_key[i] == k)
                found = i;
        gives = (o == OP_GET);
        res.hit = 1'b0;
        res.value = NO_HIT;
        if (found >= 0)
        begin
            if (o == OP_GET)
            begin
                res.hit = 1'b1;
                res.value = shadow_value[found];
            end
            else
                shadow_value[found] = v;
            // promote: entries more recent than this one age by one
            r = shadow_rank[found];
            for (int i = 0; i < N_SLOTS; i++)
                if (shadow_valid[i] && i != found && shadow_rank[i] < r)
                    shadow_rank[i]++;
            shadow_rank[found] = 0;
        end
        else if (o == OP_PUT)
        begin
            slot = 0;
            if (shadow_count >= usable_capacity())
            begin
                // evict the least recent entry and reuse its slot
                for (int i = 0; i < N_SLOTS; i++)
                    if (shadow_valid[i] && shadow_rank[i] == shadow_count - 1)
                        slot = i;
                shadow_valid[slot] = 1'b0;
                shadow_count--;
            end
            else
            begin
                for (int i = N_SLOTS - 1; i >= 0; i--)
                    if (!shadow_valid[i])
                        slot = i;
            end
            for (int i = 0; i < N_SLOTS; i++)
                if (shadow_valid[i])
                    shadow_rank[i]++;
            shadow_valid[slot] = 1'b1;
            shadow_key[slot] = k;
            shadow_value[slot] = v;
            shadow_rank[slot] = 0;
            shadow_count++;
        end
    endtask

    // Present one item and hold it until accepted
    task automatic send_item(input op_t o, input logic [31:0] k, input logic [31:0] v,
                             output bit gives, output lookup_t res);
        @(negedge clk);
        start <= 1'b1;
        op    <= o;
        key   <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_lookup(o, k, v, gives, res);
    endtask

    // Drop start with junk on the payload
    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        op    <= 1'($urandom);
        key   <= $urandom;
        value <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // Write the capacity register; ignored unless the table is empty
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        @(negedge clk);
        start     <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        if (shadow_count == 0)
            shadow_capacity = c;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every pending get, then for the pipeline to empty
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Fresh set of keys, from the usable capacity up to four more
    task automatic refresh_pool();
        pool_n = usable_capacity() + $urandom_range(0, 4);
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = $urandom;
    endtask

    task automatic note_error(input string what);
        lookup_errors++;
        if (lookup_errors <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            if (lookups_due.size() == 0)
                note_error($sformatf("unexpected result hit=%0b read_value=%h",
                                     hit, read_value));
            else
            begin
                want = lookups_due.pop_front();
                if (hit !== want.hit || read_value !== want.value)
                    note_error($sformatf("expected hit=%0b read_value=%h, got hit=%0b read_value=%h",
                                         want.hit, want.value, hit, read_value));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        bit          gives;
        lookup_t     res;
        op_t         o;
        logic [31:0] k;
        logic [31:0] corner [4];
        int          put_pct;
        int          idle_pct;
        int          pick;

        start     = 1'b0;
        op        = OP_GET;
        key       = '0;
        value     = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        lookup_errors = 0;
        cycle_count   = 0;
        corner = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        for (int i = 0; i < N_SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_count    = 0;
        shadow_capacity = CAPACITY_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Capacity can only change while empty: walk the extremes, then pick one
        write_capacity(5'd0);
        write_capacity(5'd31);
        case ($urandom_range(0, 3))
            0: write_capacity(CAP_W'($urandom_range(0, 31)));
            1: write_capacity(CAP_W'($urandom_range(1, 4)));
            2: write_capacity(CAP_W'($urandom_range(5, 16)));
            default: write_capacity(CAP_W'($urandom_range(17, 31)));
        endcase

        // Directed table
        for (int r = 0; r < DIR_N; r++)
        begin
            send_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value, gives, res);
            if (dir_rows[r].typed)
            begin
                res.hit = dir_rows[r].exp_hit;
                res.value = dir_rows[r].exp_value;
            end
            if (gives)
                lookups_due.push_back(res);
        end
        settle();

        // Random phases; each opens with a capacity write on a non-empty table, which is ignored
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                write_capacity(5'd0);
            else if (ph == 1)
                write_capacity(5'd31);
            else
                write_capacity(CAP_W'($urandom));
            refresh_pool();
            put_pct = $urandom_range(30, 70);
            idle_pct = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 64 == 0)
                    idle_pct = (ph < RAND_PHASES - 1 && $urandom_range(0, 2) != 0) ? 25 : 0;
                o = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else if (pick < 93)
                    k = $urandom;
                else
                    k = corner[$urandom_range(0, 3)];
                send_item(o, k, $urandom, gives, res);
                if (gives)
                    lookups_due.push_back(res);
                if ($urandom_range(0, 99) < idle_pct)
                    hold_off($urandom_range(1, 4));
            end
            settle();
        end

        if (lookup_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
